@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

@@ sv/fca_pkg.sv @@
// ----------------------------------------------------------------------------
// fca_pkg
// shared types and constants of the fat12 cluster allocator
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int ENTRY_W      = 12;
  localparam int SCAN_W       = ENTRY_W + 1;
  localparam int PAIR_W       = 11;
  localparam int BYTE_W       = 8;
  localparam int TABLE_ENTRIES_DEF = 4096;

  localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 12'hFFF;
  localparam logic [ENTRY_W-1:0] MEDIA_ENTRY  = 12'hFF0;
  localparam logic [ENTRY_W-1:0] LIMIT_RESET  = 12'd2863;
  localparam logic [ENTRY_W-1:0] FIRST_FREE_RESET = 12'd2;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_READ    = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_WR_LINK,
    S_WR_NEW,
    S_RD_EVEN,
    S_RD_ODD,
    S_RD_DONE,
    S_DONE
  } state_t;

endpackage

@@ sv/fca_in_if.sv @@
// ----------------------------------------------------------------------------
// fca_in_if
// command item channel: valid, ready and command payload
// ----------------------------------------------------------------------------
interface fca_in_if;
  import fca_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [ENTRY_W-1:0]  link_from;
  logic [PAIR_W-1:0]   pair_index;

  modport source (output valid, cmd, link_from, pair_index, input ready);
  modport sink   (input valid, cmd, link_from, pair_index, output ready);
endinterface

@@ sv/fca_out_if.sv @@
// ----------------------------------------------------------------------------
// fca_out_if
// result item channel: valid, ready and result payload
// ----------------------------------------------------------------------------
interface fca_out_if;
  import fca_pkg::*;

  logic                valid;
  logic                ready;
  logic                status;
  logic [ENTRY_W-1:0]  new_cluster;
  logic [BYTE_W-1:0]   packed_byte0;
  logic [BYTE_W-1:0]   packed_byte1;
  logic [BYTE_W-1:0]   packed_byte2;

  modport source (output valid, status, new_cluster, packed_byte0, packed_byte1,
                  packed_byte2, input ready);
  modport sink   (input valid, status, new_cluster, packed_byte0, packed_byte1,
                  packed_byte2, output ready);
endinterface

@@ sv/fat12_cluster_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// fat12_cluster_allocator_unit
// fat12 cluster table with first-free pointer, allocate-and-link and
// packed pair read
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over the cluster table, one entry
// per cycle, during which no command item is taken (cluster_limit writes are
// still taken). Commands are handled one at a time by a sequencer around the
// table memory, which has one read port and one write port. An allocate scans
// the table above the first-free pointer, alternating a read state and a check
// state for each entry, and if it finds a free entry writes the link and the
// new end-of-chain entry; a packed pair read reads the even and then the odd
// entry. A finished result sits in an output register, so the next command
// can be taken while it waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fat12_cluster_allocator_unit #(
  parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  fca_in_if.sink                       in_item,
  fca_out_if.source                    out_item,
  input  logic                         cfg_we,
  input  logic [fca_pkg::ENTRY_W-1:0]  cfg_wdata
);
  import fca_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam logic [SCAN_W-1:0] TBL_SIZE = SCAN_W'(TABLE_ENTRIES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);

  state_t state, state_next;

  logic [ENTRY_W-1:0] cluster_limit;
  logic [ENTRY_W-1:0] first_free;
  logic [ADDR_W-1:0]  clr_addr;
  logic [SCAN_W-1:0]  scan_c;

  logic               cmd_q;
  logic [ENTRY_W-1:0] link_q;
  logic [PAIR_W-1:0]  pair_q;

  logic               res_status;
  logic [ENTRY_W-1:0] res_new;
  logic [BYTE_W-1:0]  res_b0;
  logic [BYTE_W-1:0]  res_b1;
  logic [BYTE_W-1:0]  res_b2;

  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rdata;
  logic [ADDR_W-1:0]  raddr;
  logic               mem_we;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;

  logic [SCAN_W-1:0]  limit_eff;
  logic [SCAN_W-1:0]  link_ext;
  logic [SCAN_W-1:0]  even_idx;
  logic [SCAN_W-1:0]  odd_idx;
  logic               link_ok;
  logic               even_ok;
  logic               odd_ok;
  logic               scan_end;
  logic               scan_hit;
  logic               in_accept;
  logic               out_free;

  // compare logic and address helpers
  assign limit_eff = ({1'b0, cluster_limit} < TBL_SIZE) ? {1'b0, cluster_limit} : TBL_SIZE;
  assign link_ext  = {1'b0, link_q};
  assign even_idx  = {1'b0, pair_q, 1'b0};
  assign odd_idx   = {1'b0, pair_q, 1'b1};
  assign link_ok   = link_ext < TBL_SIZE;
  assign even_ok   = even_idx < TBL_SIZE;
  assign odd_ok    = odd_idx < TBL_SIZE;
  assign scan_end  = scan_c >= limit_eff;
  assign scan_hit  = (scan_c != link_ext) && (rdata == '0);

  assign in_item.ready = (state == S_IDLE);
  assign in_accept     = in_item.valid && in_item.ready;
  assign out_free      = !out_item.valid || out_item.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:      if (clr_addr == LAST_ADDR) state_next = S_IDLE;
      S_IDLE: begin
        if (in_accept) begin
          state_next = (in_item.cmd == CMD_READ) ? S_RD_EVEN : S_SCAN_RD;
        end
      end
      S_SCAN_RD:  state_next = scan_end ? S_DONE : S_SCAN_CHK;
      S_SCAN_CHK: state_next = scan_hit ? S_WR_LINK : S_SCAN_RD;
      S_WR_LINK:  state_next = S_WR_NEW;
      S_WR_NEW:   state_next = S_DONE;
      S_RD_EVEN:  state_next = S_RD_ODD;
      S_RD_ODD:   state_next = S_RD_DONE;
      S_RD_DONE:  state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_CLR;
    endcase
  end

  // memory control
  always_comb begin
    mem_we = 1'b0;
    waddr  = '0;
    wdata  = '0;
    raddr  = '0;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
        waddr  = clr_addr;
        if (clr_addr == ADDR_W'(0)) begin
          wdata = MEDIA_ENTRY;
        end else if (clr_addr == ADDR_W'(1)) begin
          wdata = END_OF_CHAIN;
        end
      end
      S_SCAN_RD: raddr = scan_c[ADDR_W-1:0];
      S_WR_LINK: begin
        mem_we = link_ok;
        waddr  = link_q[ADDR_W-1:0];
        wdata  = first_free;
      end
      S_WR_NEW: begin
        mem_we = 1'b1;
        waddr  = first_free[ADDR_W-1:0];
        wdata  = END_OF_CHAIN;
      end
      S_RD_EVEN: raddr = even_idx[ADDR_W-1:0];
      S_RD_ODD:  raddr = odd_idx[ADDR_W-1:0];
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_addr      <= '0;
      cluster_limit <= LIMIT_RESET;
      first_free    <= FIRST_FREE_RESET;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg_we) begin
        cluster_limit <= cfg_wdata;
      end
      if (state == S_WR_NEW) begin
        first_free <= scan_c[ENTRY_W-1:0];
      end
    end
  end

  // item registers and result assembly
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          cmd_q      <= in_item.cmd;
          link_q     <= in_item.link_from;
          pair_q     <= in_item.pair_index;
          scan_c     <= {1'b0, first_free} + SCAN_W'(1);
          res_status <= STATUS_OK;
          res_new    <= '0;
          res_b0     <= '0;
          res_b1     <= '0;
          res_b2     <= '0;
        end
      end
      S_SCAN_RD:  if (scan_end) res_status <= STATUS_FULL;
      S_SCAN_CHK: if (!scan_hit) scan_c <= scan_c + SCAN_W'(1);
      S_WR_NEW:   res_new <= first_free;
      S_RD_ODD: begin
        res_b0      <= even_ok ? rdata[7:0] : '0;
        res_b1[3:0] <= even_ok ? rdata[11:8] : '0;
      end
      S_RD_DONE: begin
        res_b1[7:4] <= odd_ok ? rdata[3:0] : '0;
        res_b2      <= odd_ok ? rdata[11:4] : '0;
      end
      default: begin
        cmd_q <= cmd_q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_item.valid <= 1'b1;
    end else if (out_item.ready) begin
      out_item.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_item.status       <= res_status;
      out_item.new_cluster  <= (cmd_q == CMD_ALLOC) ? res_new : '0;
      out_item.packed_byte0 <= res_b0;
      out_item.packed_byte1 <= res_b1;
      out_item.packed_byte2 <= res_b2;
    end
  end

  // checks
  `ASSERT_PROP(a_accept_leaves_idle, clk, rst, in_accept |=> state != S_IDLE)
  `ASSERT_PROP(a_next_above_pointer, clk, rst, (state == S_WR_NEW) |-> (scan_c > {1'b0, first_free}))
  `ASSERT_NEVER(a_full_has_no_cluster, clk, rst, out_item.valid && out_item.status && out_item.new_cluster != '0)

endmodule

@@ verif/fat12_cluster_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_cluster_allocator_unit_tb
// Sends allocate-and-link and packed pair read items, with random gaps on the
// command side and random stalls on the result side. A shadow cluster table,
// first-free pointer and cluster limit predict each result item, and every
// result is checked field by field. The cluster limit moves through tight,
// reset and maximum settings between phases so that the table fills up.
// ----------------------------------------------------------------------------
module fat12_cluster_allocator_unit_tb;
  import fca_pkg::*;

  typedef struct packed {
    logic               cmd;
    logic [ENTRY_W-1:0] link_from;
    logic [PAIR_W-1:0]  pair_index;
  } fat_cmd_t;

  typedef struct packed {
    logic               status;
    logic [ENTRY_W-1:0] new_cluster;
    logic [BYTE_W-1:0]  packed_byte0;
    logic [BYTE_W-1:0]  packed_byte1;
    logic [BYTE_W-1:0]  packed_byte2;
  } fat_reply_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [ENTRY_W-1:0] cfg_wdata;

  fca_in_if  in_ch ();
  fca_out_if out_ch ();

  fat12_cluster_allocator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [ENTRY_W-1:0] shadow_fat [0:TABLE_ENTRIES_DEF-1];
  int                 shadow_first_free;
  int                 shadow_limit;
  int                 chain_tail;

  fat_cmd_t   cmd_backlog[$];
  fat_reply_t predicted_replies[$];
  fat_cmd_t   cur_cmd;
  bit         drv_busy;
  int         in_gap;
  int         in_calm;
  int         out_stall;
  int         out_calm;
  int         error_count;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int idle_length(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic fat_reply_t predict_fat_reply(input fat_cmd_t c);
    fat_reply_t         rep;
    logic [ENTRY_W-1:0] even_e;
    logic [ENTRY_W-1:0] odd_e;
    int                 lim;
    int                 k;
    int                 nxt;
    bit                 found;
    rep = '0;
    rep.status = STATUS_OK;
    if (c.cmd == CMD_READ) begin
      even_e = shadow_fat[{c.pair_index, 1'b0}];
      odd_e  = shadow_fat[{c.pair_index, 1'b1}];
      rep.packed_byte0 = even_e[7:0];
      rep.packed_byte1 = {odd_e[3:0], even_e[11:8]};
      rep.packed_byte2 = odd_e[11:4];
    end else begin
      lim = (shadow_limit > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : shadow_limit;
      found = 1'b0;
      nxt = 0;
      for (k = shadow_first_free + 1; k < lim; k++) begin
        if (k != int'(c.link_from) && shadow_fat[k] == '0) begin
          found = 1'b1;
          nxt = k;
          break;
        end
      end
      if (!found || shadow_first_free >= lim) begin
        rep.status = STATUS_FULL;
      end else begin
        shadow_fat[c.link_from] = ENTRY_W'(shadow_first_free);
        shadow_fat[shadow_first_free] = END_OF_CHAIN;
        rep.new_cluster = ENTRY_W'(shadow_first_free);
        chain_tail = shadow_first_free;
        shadow_first_free = nxt;
      end
    end
    return rep;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
    error_count++;
  endtask

  task automatic push_cmd(input logic cmd, input int link, input int pair);
    fat_cmd_t c;
    c.cmd = cmd;
    c.link_from = ENTRY_W'(link);
    c.pair_index = PAIR_W'(pair);
    cmd_backlog.push_back(c);
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || drv_busy || predicted_replies.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ENTRY_W'(value);
    shadow_limit = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic feed_random(input int count);
    int i;
    int r;
    int hi;
    for (i = 0; i < count; i++) begin
      while (cmd_backlog.size() >= 2) @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        r = $urandom_range(0, 99);
        if (r < 45) push_cmd(CMD_ALLOC, chain_tail, 0);
        else if (r < 65) push_cmd(CMD_ALLOC, shadow_first_free, 0);
        else if (r < 80) push_cmd(CMD_ALLOC, (shadow_first_free + $urandom_range(1, 8)) & 'hFFF, 0);
        else push_cmd(CMD_ALLOC, $urandom_range(0, 4095), $urandom_range(0, 2047));
      end else begin
        r = $urandom_range(0, 99);
        hi = shadow_first_free / 2 + 2;
        if (hi > 2047) hi = 2047;
        if (r < 50) push_cmd(CMD_READ, $urandom_range(0, 4095), $urandom_range(0, hi));
        else if (r < 70) push_cmd(CMD_READ, 0, hi);
        else push_cmd(CMD_READ, $urandom_range(0, 4095), $urandom_range(0, 2047));
      end
    end
  endtask

  // command side: accept and predict
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      predicted_replies.push_back(predict_fat_reply(cur_cmd));
      drv_busy = 1'b0;
      in_gap = idle_length(in_calm);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!drv_busy) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap--;
      end else if (cmd_backlog.size() > 0) begin
        cur_cmd = cmd_backlog.pop_front();
        in_ch.cmd <= cur_cmd.cmd;
        in_ch.link_from <= cur_cmd.link_from;
        in_ch.pair_index <= cur_cmd.pair_index;
        in_ch.valid <= 1'b1;
        drv_busy = 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side: check each item
  always @(posedge clk) begin
    fat_reply_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (predicted_replies.size() == 0) begin
        report_mismatch("unexpected result item, new_cluster", out_ch.new_cluster, 0);
      end else begin
        want = predicted_replies.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.new_cluster !== want.new_cluster)
          report_mismatch("new_cluster", out_ch.new_cluster, want.new_cluster);
        if (out_ch.packed_byte0 !== want.packed_byte0)
          report_mismatch("packed_byte0", out_ch.packed_byte0, want.packed_byte0);
        if (out_ch.packed_byte1 !== want.packed_byte1)
          report_mismatch("packed_byte1", out_ch.packed_byte1, want.packed_byte1);
        if (out_ch.packed_byte2 !== want.packed_byte2)
          report_mismatch("packed_byte2", out_ch.packed_byte2, want.packed_byte2);
      end
      out_stall = idle_length(out_calm);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    int p;
    int lim;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ALLOC;
    in_ch.link_from = '0;
    in_ch.pair_index = '0;
    out_ch.ready = 1'b0;
    drv_busy = 1'b0;
    in_gap = 0;
    in_calm = 0;
    out_stall = 0;
    out_calm = 0;
    error_count = 0;
    foreach (shadow_fat[i]) shadow_fat[i] = '0;
    shadow_fat[0] = MEDIA_ENTRY;
    shadow_fat[1] = END_OF_CHAIN;
    shadow_first_free = FIRST_FREE_RESET;
    shadow_limit = LIMIT_RESET;
    chain_tail = FIRST_FREE_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset limit: media and end-of-chain entries, packing, chain starts
    push_cmd(CMD_READ, 0, 0);
    push_cmd(CMD_READ, 4095, 2047);
    push_cmd(CMD_READ, 0, 1);
    push_cmd(CMD_ALLOC, 2, 0);
    push_cmd(CMD_ALLOC, 3, 0);
    push_cmd(CMD_ALLOC, 5, 0);
    push_cmd(CMD_ALLOC, 4095, 2047);
    push_cmd(CMD_ALLOC, 0, 0);
    push_cmd(CMD_ALLOC, 7, 0);
    push_cmd(CMD_READ, 0, 0);
    push_cmd(CMD_READ, 0, 1);
    push_cmd(CMD_READ, 0, 2);
    push_cmd(CMD_READ, 0, 3);
    push_cmd(CMD_READ, 0, 2047);
    wait_drained();

    // pointer already at or past the limit
    write_limit(3);
    push_cmd(CMD_ALLOC, 8, 0);
    push_cmd(CMD_ALLOC, 4095, 0);
    push_cmd(CMD_READ, 0, 1);
    wait_drained();

    // pointer below the limit but nothing free above it
    write_limit(shadow_first_free + 1);
    push_cmd(CMD_ALLOC, 8, 0);
    push_cmd(CMD_ALLOC, 1, 0);
    wait_drained();

    write_limit(4095);
    push_cmd(CMD_ALLOC, 9, 0);
    push_cmd(CMD_ALLOC, 2048, 0);
    push_cmd(CMD_READ, 0, 1024);
    wait_drained();

    for (p = 0; p < 8; p++) begin
      if (p == 7) begin
        lim = 4095;
      end else begin
        case ($urandom_range(0, 3))
          0: lim = shadow_first_free + $urandom_range(3, 40);
          1: lim = shadow_first_free + $urandom_range(100, 500);
          2: lim = LIMIT_RESET;
          default: lim = 4095;
        endcase
      end
      if (lim > 4095) lim = 4095;
      if (lim < 3) lim = 3;
      write_limit(lim);
      feed_random(230);
      wait_drained();
    end

    repeat (50) @(negedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
